// ----- hdl/kvt_pkg.sv -----
// shared types and codes for the small key/value table
package kvt_pkg;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [15:0]         key;
    logic signed [31:0]  value;
  } item_t;

  typedef struct packed {
    logic signed [31:0]  result_value;
    logic [1:0]          status;
    logic [4:0]          entry_count;
  } result_t;

  // classified command as it travels from front to back
  typedef struct packed {
    cmd_e                cmd;
    logic                search;
    logic [15:0]         key;
    logic signed [31:0]  value;
  } op_t;

  typedef struct packed {
    logic [15:0]         key;
    logic signed [31:0]  value;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT
  } back_state_e;

endpackage

// ----- hdl/kvt_ram.sv -----
// generic single write, single read ram with registered read data
module kvt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/kvt_fifo.sv -----
// two-entry queue used for the command and result queues of the table
module kvt_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- hdl/kvt_front.sv -----
// front end: takes items, classifies the command and queues it for the back end
module kvt_front
  import kvt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output op_t   op,
  output logic  op_valid,
  input  logic  op_pop
);

  op_t  op_in;
  logic q_empty;
  logic [$bits(op_t)-1:0] q_rdata;

  always_comb begin
    op_in.cmd    = cmd_e'(item.cmd);
    op_in.search = (cmd_e'(item.cmd) != CMD_CLEAR);
    op_in.key    = item.key;
    op_in.value  = item.value;
  end

  kvt_fifo #(
    .WIDTH ($bits(op_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (op_in),
    .full  (full),
    .pop   (op_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign op   = op_t'(q_rdata);
  assign op_valid = !q_empty;

endmodule

// ----- hdl/kvt_back.sv -----
// back end: linear search, update and compaction of the table ram
module kvt_back
  import kvt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  op_t     op,
  input  logic    op_valid,
  output logic    op_pop,
  input  logic    res_room,
  output logic    res_push,
  output result_t res,
  output logic    ram_we,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
  output entry_t  ram_wdata,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
  input  entry_t  ram_rdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  back_state_e        state;
  back_state_e        state_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [CNT_W-1:0]   scan;
  logic [CNT_W-1:0]   chk;
  logic               chk_vld;
  op_t                cur;
  logic signed [31:0] hit_val;

  logic start;
  logic key_hit;
  logic last_chk;

  assign start    = (state == S_IDLE) && op_valid && res_room;
  assign key_hit  = chk_vld && (ram_rdata.key == cur.key);
  assign last_chk = (chk == cnt - CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && op.search && (cnt != '0)) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (key_hit) begin
          if ((cur.cmd == CMD_REMOVE) && !last_chk) begin
            state_next = S_SHIFT;
          end else begin
            state_next = S_IDLE;
          end
        end else if (chk_vld && last_chk) begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (last_chk) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and count update
  always_comb begin
    op_pop           = 1'b0;
    res_push         = 1'b0;
    res.result_value = '0;
    res.status       = ST_OK;
    ram_we           = 1'b0;
    ram_waddr        = chk[IDX_W-1:0];
    ram_wdata.key    = cur.key;
    ram_wdata.value  = cur.value;
    ram_raddr        = scan[IDX_W-1:0];
    cnt_next         = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          op_pop = 1'b1;
          if (!op.search) begin
            res_push = 1'b1;
            cnt_next = '0;
          end else if (cnt == '0) begin
            res_push = 1'b1;
            if (op.cmd == CMD_PUT) begin
              ram_we          = 1'b1;
              ram_waddr       = '0;
              ram_wdata.key   = op.key;
              ram_wdata.value = op.value;
              cnt_next        = CNT_W'(1);
            end else begin
              res.status = ST_MISSING;
            end
          end
        end
      end
      S_SEARCH: begin
        if (key_hit) begin
          case (cur.cmd)
            CMD_PUT: begin
              ram_we   = 1'b1;
              res_push = 1'b1;
            end
            CMD_REMOVE: begin
              // last entry needs no compaction
              if (last_chk) begin
                res_push         = 1'b1;
                res.result_value = ram_rdata.value;
                cnt_next         = cnt - CNT_W'(1);
              end
            end
            default: begin
              res_push         = 1'b1;
              res.result_value = ram_rdata.value;
            end
          endcase
        end else if (chk_vld && last_chk) begin
          res_push = 1'b1;
          if (cur.cmd == CMD_PUT) begin
            if (cnt >= CNT_W'(TABLE_DEPTH)) begin
              res.status = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt[IDX_W-1:0];
              cnt_next  = cnt + CNT_W'(1);
            end
          end else begin
            res.status = ST_MISSING;
          end
        end
      end
      S_SHIFT: begin
        // move the entry read last cycle down by one place
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(chk - CNT_W'(1));
        ram_wdata = ram_rdata;
        if (last_chk) begin
          res_push         = 1'b1;
          res.result_value = hit_val;
          cnt_next         = cnt - CNT_W'(1);
        end
      end
      default: ;
    endcase
    res.entry_count = 5'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      chk_vld <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_IDLE) begin
        chk_vld <= 1'b0;
      end else begin
        chk_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      scan <= '0;
    end else begin
      scan <= scan + CNT_W'(1);
      chk  <= scan;
    end
    if (start) begin
      cur <= op;
    end
    if (key_hit) begin
      hit_val <= ram_rdata.value;
    end
  end

endmodule

// ----- hdl/small_key_value_table.sv -----
// key/value table top level: input queue, search sequencer, table ram and result queue
// each search scans the table ram through its single read port, one entry per cycle;
//   a remove then moves the entries behind the hit down; clear and operations on an
//   empty table need no scan. The back end starts a new item only once it is done
//   with the last one; further items wait in the input queue
// reset: synchronous, clears the entry count and both queues; table ram contents are kept
module small_key_value_table
  import kvt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  op_t              op;
  logic             op_valid;
  logic             op_pop;
  logic             res_push;
  logic             res_full;
  result_t          res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  logic [$bits(result_t)-1:0] res_rdata;

  kvt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .op       (op),
    .op_valid (op_valid),
    .op_pop   (op_pop)
  );

  kvt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .op_valid  (op_valid),
    .op_pop    (op_pop),
    .res_room  (!res_full),
    .res_push  (res_push),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (entry_t'(ram_rdata))
  );

  kvt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kvt_fifo #(
    .WIDTH ($bits(result_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = result_t'(res_rdata);

endmodule

// ----- bench/small_key_value_table_check.sv -----
`timescale 1ns / 100ps
// checker for the key/value table: predicts every result and compares it at the output
module small_key_value_table_check
  import kvt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  item_t   item,
  input  logic    empty,
  input  logic    pop,
  input  result_t result,
  output int      failures,
  output int      outstanding,
  output int      ops_seen,
  output int      results_seen,
  output int      refused_puts,
  output int      missed_keys
);

  logic [15:0]        key_store   [TABLE_DEPTH];
  logic signed [31:0] value_store [TABLE_DEPTH];
  int                 fill;
  result_t            owed_results [$];
  result_t            want;

  // applies one operation to the local copy of the table and returns its result
  function automatic result_t table_outcome(item_t op);
    result_t r;
    int      slot;
    r.result_value = '0;
    r.status       = ST_OK;
    r.entry_count  = '0;
    slot = fill;
    // scan downward so the oldest matching entry wins
    for (int i = fill - 1; i >= 0; i--)
      if (key_store[i] == op.key) slot = i;
    case (cmd_e'(op.cmd))
      CMD_PUT: begin
        if (slot < fill) begin
          value_store[slot] = op.value;
        end else if (fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          key_store[fill]   = op.key;
          value_store[fill] = op.value;
          fill++;
        end
      end
      CMD_REMOVE: begin
        if (slot < fill) begin
          r.result_value = value_store[slot];
          for (int i = slot; i + 1 < fill; i++) begin
            key_store[i]   = key_store[i + 1];
            value_store[i] = value_store[i + 1];
          end
          fill--;
        end else begin
          r.status = ST_MISSING;
        end
      end
      CMD_GET: begin
        if (slot < fill) r.result_value = value_store[slot];
        else r.status = ST_MISSING;
      end
      default: fill = 0;
    endcase
    r.entry_count = 5'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      owed_results.delete();
    end else begin
      // output side first: a result can never belong to an item taken at the same edge
      if (pop && !empty) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with nothing expected: value %0d status %0d count %0d",
                     $realtime, result.result_value, result.status, result.entry_count);
        end else begin
          want = owed_results.pop_front();
          if (result.result_value !== want.result_value || result.status !== want.status ||
              result.entry_count !== want.entry_count) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch: value %0d/%0d status %0d/%0d count %0d/%0d (exp/got)",
                       $realtime, want.result_value, result.result_value, want.status,
                       result.status, want.entry_count, result.entry_count);
          end
        end
      end
      if (push && !full) begin
        ops_seen++;
        want = table_outcome(item);
        if (want.status == ST_FULL) refused_puts++;
        if (want.status == ST_MISSING) missed_keys++;
        owed_results.push_back(want);
      end
    end
    outstanding <= owed_results.size();
  end

endmodule

// ----- bench/small_key_value_table_test.sv -----
`timescale 1ns / 100ps
// top of the key/value table testbench: clock, reset, stimulus, result drain and verdict
module small_key_value_table_test;
  import kvt_pkg::*;

  localparam int DEPTH       = 16;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_OPS   = 275;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  item_t       item;
  logic        empty;
  logic        pop;
  result_t     result;
  int          failures;
  int          outstanding;
  int          ops_seen;
  int          results_seen;
  int          refused_puts;
  int          missed_keys;
  int          quiet_cycles;
  bit          steady;
  logic [15:0] key_pool [64];

  small_key_value_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  small_key_value_table_check #(.TABLE_DEPTH(DEPTH)) table_check (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .item         (item),
    .empty        (empty),
    .pop          (pop),
    .result       (result),
    .failures     (failures),
    .outstanding  (outstanding),
    .ops_seen     (ops_seen),
    .results_seen (results_seen),
    .refused_puts (refused_puts),
    .missed_keys  (missed_keys)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one; none at all in steady stretches
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'sh7FFF_FFFF;
    if (r == 1) return 32'sh8000_0000;
    if (r == 2) return '0;
    return 32'($urandom);
  endfunction

  // holds push high until the transfer happens
  task automatic send_op(input cmd_e c, input logic [15:0] k, input logic signed [31:0] v);
    int    gap;
    item_t op;
    gap = idle_gap();
    op.cmd   = c;
    op.key   = k;
    op.value = v;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= op;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // keys mostly from a small pool so that puts, gets and removes hit each other
  task automatic run_phase(input int put_pct, input int remove_pct, input int clear_pct,
                           input int pool_size, input int wide_pct, input bit no_idle);
    int          r;
    logic [15:0] k;
    for (int i = 0; i < pool_size; i++) key_pool[i] = 16'($urandom);
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    steady = no_idle;
    repeat (PHASE_OPS) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < wide_pct) k = 16'($urandom);
      else k = key_pool[$urandom_range(0, pool_size - 1)];
      if (r < put_pct) send_op(CMD_PUT, k, pick_value());
      else if (r < put_pct + remove_pct) send_op(CMD_REMOVE, k, pick_value());
      else if (r < put_pct + remove_pct + clear_pct) send_op(CMD_CLEAR, k, pick_value());
      else send_op(CMD_GET, k, pick_value());
    end
  endtask

  // result side: pop stays high until a transfer, then a random stall
  initial begin : result_drain
    int stall;
    pop <= 1'b0;
    repeat (8) @(posedge clk);
    forever begin
      stall = idle_gap();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("no transfer for %0d cycles, giving up", QUIET_LIMIT);
      $display("** small_key_value_table: FAILED **");
      $finish;
    end
  end

  initial begin
    rst  <= 1'b1;
    push <= 1'b0;
    item <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // lookups on an empty table
    send_op(CMD_GET, 16'h0000, 32'sh1234_5678);
    send_op(CMD_REMOVE, 16'hFFFF, '0);
    // extreme keys and values, then an update in place
    send_op(CMD_PUT, 16'h0000, 32'sh7FFF_FFFF);
    send_op(CMD_PUT, 16'hFFFF, 32'sh8000_0000);
    send_op(CMD_PUT, 16'h0000, -32'sd1);
    send_op(CMD_GET, 16'h0000, '0);
    // fill to capacity, refuse a new key, update a key that is present
    for (int k = 1; k <= DEPTH - 2; k++) send_op(CMD_PUT, 16'(k), pick_value());
    send_op(CMD_PUT, 16'h8000, 32'sh5555_AAAA);
    send_op(CMD_PUT, 16'd7, '0);
    // removes from the middle, the front and the back
    send_op(CMD_REMOVE, 16'd7, '0);
    send_op(CMD_REMOVE, 16'h0000, '0);
    send_op(CMD_REMOVE, 16'(DEPTH - 2), '0);
    send_op(CMD_CLEAR, 16'hA5A5, 32'shFFFF_FFFF);
    send_op(CMD_GET, 16'd1, '0);

    run_phase(60, 15, 2, 20, 5, 1'b0);
    run_phase(40, 25, 2, 24, 5, 1'b1);
    run_phase(30, 40, 2, 12, 5, 1'b0);
    run_phase(45, 20, 5, 18, 20, 1'b0);
    run_phase(35, 30, 5, 40, 10, 1'b0);
    run_phase(50, 20, 2, 20, 5, 1'b0);
    push <= 1'b0;

    // let the checker count the last transfer before waiting on it
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("ran %0d table operations, %0d results checked, %0d failures",
             ops_seen, results_seen, failures + outstanding);
    $display("saw %0d puts refused on a full table, %0d gets or removes of absent keys",
             refused_puts, missed_keys);
    if (failures == 0 && outstanding == 0) begin
      $display("** small_key_value_table: PASSED **");
    end else begin
      $display("** small_key_value_table: FAILED **");
    end
    $finish;
  end

endmodule
